>>> hw/rtl/rotated_cursor_overlay_blend_core_macros.svh
// Assertion helpers for the cursor overlay core.
`ifndef ROTATED_CURSOR_OVERLAY_BLEND_CORE_MACROS_SVH
`define ROTATED_CURSOR_OVERLAY_BLEND_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcob assertion failed");

// Next-cycle implication, disabled during reset.
`define RCOB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcob assertion failed");

`endif

>>> hw/rtl/rcob_pkg.sv
`default_nettype none

package rcob_pkg;

    // Cursor image geometry
    localparam int MAX_SIDE = 128;
    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int SIDE_W   = 8;

    // Field widths
    localparam int COORD_W    = 14;
    localparam int PIX_W      = 32;
    localparam int POS_W      = 15;
    localparam int FRAME_W    = 15;
    localparam int OFF_W      = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    typedef logic [1:0]        t_mode;
    typedef logic [1:0]        t_rot;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SIDE_W-1:0] t_side;
    typedef logic [PIX_W-1:0]  t_pix;

    // Cursor modes
    localparam t_mode MODE_HIDDEN = 2'd0;
    localparam t_mode MODE_MONO   = 2'd1;
    localparam t_mode MODE_ALPHA  = 2'd2;
    localparam t_mode MODE_MASKED = 2'd3;

    // Rotations
    localparam t_rot ROT_0   = 2'd0;
    localparam t_rot ROT_90  = 2'd1;
    localparam t_rot ROT_180 = 2'd2;
    localparam t_rot ROT_270 = 2'd3;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_W   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_H   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 3'd7;

    // Operands handed to the blend stage
    typedef struct packed {
        t_pix cur;
        t_pix dst;
        logic covered;
    } t_blend_in;

endpackage

`default_nettype wire

>>> hw/rtl/rcob_if.sv
`default_nettype none

// Pixel input channel
interface rcob_in_if;
    import rcob_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [PIX_W-1:0]     pixel_word;

    modport source (output valid, kind, coord_x, coord_y, pixel_word, input ready);
    modport sink   (input valid, kind, coord_x, coord_y, pixel_word, output ready);
endinterface

// Blended pixel output channel
interface rcob_out_if;
    import rcob_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   out_pixel;
    logic               covered;

    modport source (output valid, out_pixel, covered, input ready);
    modport sink   (input valid, out_pixel, covered, output ready);
endinterface

// Register write channel
interface rcob_cfg_if;
    import rcob_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rcob_blend.sv
`default_nettype none

// Channel blend: products and mono/masked results in one stage, then
// rounded divide by 255 and final select on the registered values.
module rcob_blend (
    input  logic                i_clk,
    input  logic                i_en,
    input  rcob_pkg::t_mode     i_mode,
    input  rcob_pkg::t_blend_in i_in,
    output rcob_pkg::t_pix      o_pixel,
    output logic                o_covered
);
    import rcob_pkg::*;

    logic [7:0]  al;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  dch [3];
    logic [7:0]  sch [3];
    logic [15:0] n_sum [3];
    logic [7:0]  n_alt [3];
    logic [15:0] r_sum [3];
    logic [7:0]  r_alt [3];
    logic [7:0]  quo [3];
    logic        r_sel_alpha;
    logic        r_covered;
    t_pix        r_dst;

    assign al = i_in.cur[31:24];
    assign a0 = i_in.cur[7:0];
    assign a1 = i_in.cur[15:8];

    // Per-channel weighted sum and non-alpha results
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dch[c]   = i_in.dst[8*c +: 8];
            sch[c]   = i_in.cur[8*c +: 8];
            n_sum[c] = 16'(sch[c] * al) + 16'(dch[c] * (8'd255 - al)) + 16'd127;
            if (i_mode == MODE_MONO) begin
                n_alt[c] = (dch[c] & a0) ^ a1;
            end else begin
                n_alt[c] = (al != 8'd0) ? (dch[c] ^ sch[c]) : sch[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= n_sum[c];
                r_alt[c] <= n_alt[c];
            end
            r_sel_alpha <= (i_mode != MODE_MONO) && (i_mode != MODE_MASKED);
            r_covered   <= i_in.covered;
            r_dst       <= i_in.dst;
        end
    end

    // v / 255 as (v + 1 + (v >> 8)) >> 8, exact below 65535
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            quo[c] = 8'((17'(r_sum[c]) + 17'd1 + 17'(r_sum[c] >> 8)) >> 8);
        end
    end

    // Channel 3 always passes; uncovered pixels pass whole
    always_comb begin
        o_pixel = r_dst;
        if (r_covered) begin
            for (int c = 0; c < 3; c++) begin
                o_pixel[8*c +: 8] = r_sel_alpha ? quo[c] : r_alt[c];
            end
        end
    end

    assign o_covered = r_covered;

endmodule

`default_nettype wire

>>> hw/rtl/rotated_cursor_overlay_blend_core.sv
// Hardware cursor overlay with rotation.
// i_in carries two kinds of transaction: a load writes one cursor pixel into
// the 128x128 cursor image, a frame transaction carries a destination pixel
// with its coordinates. Each frame transaction yields exactly one transaction
// on o_out (blended pixel plus covered flag); loads yield none.
// i_cfg writes the eight control registers; write them only while idle.
// Pipeline: placement offsets, then the cursor image access (one
// single-port RAM, read or write per cycle), then the blend products, then
// the divide and output register. One transaction per cycle is accepted
// while o_out does not stall; the single RAM port serves one load or one
// frame pixel per cycle. When o_out stalls, the whole pipeline holds and
// i_in.ready drops until the output register is taken. Reset clears the
// control registers and the pipeline valids and holds both ready lines
// low; the cursor image is not cleared and must be loaded before it is
// shown.
`default_nettype none

`include "rotated_cursor_overlay_blend_core_macros.svh"

module rotated_cursor_overlay_blend_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcob_in_if.sink    i_in,
    rcob_out_if.source o_out,
    rcob_cfg_if.sink   i_cfg
);
    import rcob_pkg::*;

    // Control registers
    t_mode                    r_mode;
    t_side                    r_cur_w;
    t_side                    r_cur_h;
    t_rot                     r_rot;
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic [FRAME_W-1:0]       r_frame_w;
    logic [FRAME_W-1:0]       r_frame_h;

    logic adv;

    // Stage 1
    logic                     r_v1;
    logic                     r_k1;
    logic                     r_ld_ok1;
    t_idx                     r_lx1;
    t_idx                     r_ly1;
    t_pix                     r_word1;
    logic signed [OFF_W-1:0]  r_dx1;
    logic signed [OFF_W-1:0]  r_dy1;
    logic                     r_act1;

    // Stage 2
    logic                     r_v2;
    logic                     r_cov2;
    t_pix                     r_word2;
    t_pix                     r_cur;

    // Stage 3 and output
    logic                     r_v3;
    logic                     r_out_valid;
    t_pix                     r_out_pixel;
    logic                     r_out_covered;

    // Cursor image
    t_pix                     r_mem [DEPTH];
    logic [ADDR_W-1:0]        mem_addr;
    t_pix                     mem_wdata;
    logic                     mem_we;
    logic                     mem_re;

    t_side                    cw;
    t_side                    ch;
    logic signed [OFF_W-1:0]  w_s;
    logic signed [OFF_W-1:0]  h_s;
    logic signed [OFF_W-1:0]  px_s;
    logic signed [OFF_W-1:0]  py_s;
    logic signed [OFF_W-1:0]  fw_s;
    logic signed [OFF_W-1:0]  fh_s;
    logic signed [OFF_W-1:0]  rx;
    logic signed [OFF_W-1:0]  ry;
    logic signed [OFF_W-1:0]  n_dx;
    logic signed [OFF_W-1:0]  n_dy;
    logic                     n_act;

    t_side                    rw;
    t_side                    rh;
    logic                     x_in;
    logic                     y_in;
    t_idx                     xi;
    t_idx                     yi;
    t_side                    w_m_x;
    t_side                    w_m_y;
    t_side                    h_m_x;
    t_side                    h_m_y;
    t_idx                     sx;
    t_idx                     sy;

    t_blend_in                blend_in;
    t_pix                     blend_pixel;
    logic                     blend_covered;

    // Register writes
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_HIDDEN;
            r_cur_w   <= '0;
            r_cur_h   <= '0;
            r_rot     <= ROT_0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_frame_w <= '0;
            r_frame_h <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:    r_mode    <= i_cfg.data[1:0];
                REG_CUR_W:   r_cur_w   <= i_cfg.data[SIDE_W-1:0];
                REG_CUR_H:   r_cur_h   <= i_cfg.data[SIDE_W-1:0];
                REG_ROT:     r_rot     <= i_cfg.data[1:0];
                REG_POS_X:   r_pos_x   <= signed'(i_cfg.data[POS_W-1:0]);
                REG_POS_Y:   r_pos_y   <= signed'(i_cfg.data[POS_W-1:0]);
                REG_FRAME_W: r_frame_w <= i_cfg.data[FRAME_W-1:0];
                REG_FRAME_H: r_frame_h <= i_cfg.data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = adv && i_rst_n;

    // Saturated cursor size and rotated rectangle origin
    assign cw   = (r_cur_w > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_cur_w;
    assign ch   = (r_cur_h > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_cur_h;
    assign w_s  = signed'(OFF_W'(cw));
    assign h_s  = signed'(OFF_W'(ch));
    assign px_s = OFF_W'(r_pos_x);
    assign py_s = OFF_W'(r_pos_y);
    assign fw_s = signed'(OFF_W'(r_frame_w));
    assign fh_s = signed'(OFF_W'(r_frame_h));

    always_comb begin
        case (r_rot)
            ROT_90: begin
                rx = py_s;
                ry = fh_s - px_s - w_s;
            end
            ROT_180: begin
                rx = fw_s - px_s - w_s;
                ry = fh_s - py_s - h_s;
            end
            ROT_270: begin
                rx = fw_s - py_s - h_s;
                ry = px_s;
            end
            default: begin
                rx = px_s;
                ry = py_s;
            end
        endcase
    end

    assign n_dx  = signed'(OFF_W'(i_in.coord_x)) - rx;
    assign n_dy  = signed'(OFF_W'(i_in.coord_y)) - ry;
    assign n_act = (r_mode != MODE_HIDDEN) && (cw != '0) && (ch != '0)
                && ({1'b0, i_in.coord_x} < r_frame_w)
                && ({1'b0, i_in.coord_y} < r_frame_h);

    // Stage 1 capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k1     <= i_in.kind;
            r_ld_ok1 <= (i_in.coord_x < COORD_W'(MAX_SIDE))
                     && (i_in.coord_y < COORD_W'(MAX_SIDE));
            r_lx1    <= i_in.coord_x[IDX_W-1:0];
            r_ly1    <= i_in.coord_y[IDX_W-1:0];
            r_word1  <= i_in.pixel_word;
            r_dx1    <= n_dx;
            r_dy1    <= n_dy;
            r_act1   <= n_act;
        end
    end

    // Rectangle test and mapping back to cursor coordinates
    assign rw   = (r_rot == ROT_90 || r_rot == ROT_270) ? ch : cw;
    assign rh   = (r_rot == ROT_90 || r_rot == ROT_270) ? cw : ch;
    assign x_in = !r_dx1[OFF_W-1] && (r_dx1 < signed'(OFF_W'(rw)));
    assign y_in = !r_dy1[OFF_W-1] && (r_dy1 < signed'(OFF_W'(rh)));
    assign xi   = r_dx1[IDX_W-1:0];
    assign yi   = r_dy1[IDX_W-1:0];

    assign w_m_x = cw - SIDE_W'(1) - SIDE_W'(xi);
    assign w_m_y = cw - SIDE_W'(1) - SIDE_W'(yi);
    assign h_m_x = ch - SIDE_W'(1) - SIDE_W'(xi);
    assign h_m_y = ch - SIDE_W'(1) - SIDE_W'(yi);

    always_comb begin
        case (r_rot)
            ROT_90: begin
                sx = w_m_y[IDX_W-1:0];
                sy = xi;
            end
            ROT_180: begin
                sx = w_m_x[IDX_W-1:0];
                sy = h_m_y[IDX_W-1:0];
            end
            ROT_270: begin
                sx = yi;
                sy = h_m_x[IDX_W-1:0];
            end
            default: begin
                sx = xi;
                sy = yi;
            end
        endcase
    end

    // Single-port access: a load writes, a frame pixel reads
    assign mem_addr  = (r_k1 == KIND_LOAD) ? {r_ly1, r_lx1} : {sy, sx};
    assign mem_wdata = (r_mode == MODE_MONO)
                     ? {16'h0000, {8{r_word1[1]}}, {8{r_word1[0]}}} : r_word1;
    assign mem_we    = adv && r_v1 && (r_k1 == KIND_LOAD) && r_ld_ok1;
    assign mem_re    = adv && r_v1 && (r_k1 == KIND_FRAME);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_cur <= r_mem[mem_addr];
        end
    end

    // Stage 2 and stage 3 valids: frame transactions only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1 && (r_k1 == KIND_FRAME);
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cov2  <= r_act1 && x_in && y_in;
            r_word2 <= r_word1;
        end
    end

    assign blend_in = '{cur: r_cur, dst: r_word2, covered: r_cov2};

    rcob_blend u_blend (
        .i_clk     (i_clk),
        .i_en      (adv),
        .i_mode    (r_mode),
        .i_in      (blend_in),
        .o_pixel   (blend_pixel),
        .o_covered (blend_covered)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pixel   <= blend_pixel;
            r_out_covered <= blend_covered;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_pixel = r_out_pixel;
    assign o_out.covered   = r_out_covered;

    // Checks
    `RCOB_ASSERT_NXT(a_frame_enters, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.kind == KIND_FRAME), r_v1 && (r_k1 == KIND_FRAME))
    `RCOB_ASSERT_NXT(a_load_no_result, i_clk, i_rst_n, r_v1 && (r_k1 == KIND_LOAD) && adv, !r_v2)
    `RCOB_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, r_v3 && adv, r_out_valid)
    `RCOB_ASSERT_IMP(a_stall_backs_up, i_clk, i_rst_n, r_out_valid && !o_out.ready, !i_in.ready && !mem_we && !mem_re)

endmodule

`default_nettype wire
